FILE: sv/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared types, constants and helpers of the quaternion to rotation matrix
// core.
// ----------------------------------------------------------------------------
package qrm_pkg;

    // One in Q2.14.
    localparam logic signed [15:0] QONE  = 16'sd16384;
    // Number of quotient bits; every entry magnitude is at most 2^14.
    localparam int unsigned        Q_BITS = 15;
    // Width of the sum of squares.
    localparam int unsigned        N_W    = 33;
    // Width of the dividend and partial remainder.
    localparam int unsigned        REM_W  = 48;
    // Width of a signed numerator before scaling.
    localparam int unsigned        NUM_W  = 35;
    // Number of matrix entries.
    localparam int unsigned        N_ENT  = 9;

    typedef struct packed {
        logic signed [31:0] xx;
        logic signed [31:0] yy;
        logic signed [31:0] zz;
        logic signed [31:0] ww;
        logic signed [31:0] xy;
        logic signed [31:0] xz;
        logic signed [31:0] yz;
        logic signed [31:0] xw;
        logic signed [31:0] yw;
        logic signed [31:0] zw;
    } t_prod;

    typedef struct packed {
        logic [N_W-1:0]                    n;
        logic                              zero;
        logic [N_ENT-1:0]                  neg;
        logic [N_ENT-1:0][REM_W-1:0]       rem;
        logic [N_ENT-1:0][Q_BITS-1:0]      quo;
    } t_div;

    typedef struct packed {
        logic             neg;
        logic [REM_W-1:0] rem;
    } t_lane;

    // Build the rounded dividend |num| * 2^shift + n/2 and remember the sign.
    // Diagonal entries scale by 2^14, off-diagonal entries by 2^15.
    function automatic t_lane make_lane(input logic signed [NUM_W-1:0] num,
                                        input logic                    diag,
                                        input logic [N_W-1:0]          n);
        t_lane            l;
        logic [NUM_W-1:0] mag;
        logic [REM_W-1:0] sh;
        l.neg = num[NUM_W-1];
        mag   = l.neg ? NUM_W'(-num) : NUM_W'(num);
        sh    = diag ? (REM_W'(mag) << 14) : (REM_W'(mag) << 15);
        l.rem = sh + REM_W'(n >> 1);
        return l;
    endfunction

endpackage

FILE: sv/qrm_if.sv
// ----------------------------------------------------------------------------
// qrm_in_if / qrm_out_if
// Valid/ready channels carrying one quaternion request and one matrix result.
// ----------------------------------------------------------------------------
interface qrm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
    logic signed [15:0] q_w;

    modport source (output valid, q_x, q_y, q_z, q_w, input ready);
    modport sink   (input valid, q_x, q_y, q_z, q_w, output ready);
endinterface

interface qrm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               zero_norm;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    zero_norm, input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    zero_norm, output ready);
endinterface

FILE: sv/qrm_prod.sv
// ----------------------------------------------------------------------------
// qrm_prod
// Registered stage forming the ten pairwise products of the components.
// ----------------------------------------------------------------------------
module qrm_prod (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [15:0]   i_x,
    input  logic signed [15:0]   i_y,
    input  logic signed [15:0]   i_z,
    input  logic signed [15:0]   i_w,
    output qrm_pkg::t_prod       o_prod
);
    qrm_pkg::t_prod n_prod;
    qrm_pkg::t_prod r_prod;

    always_comb begin
        n_prod.xx = i_x * i_x;
        n_prod.yy = i_y * i_y;
        n_prod.zz = i_z * i_z;
        n_prod.ww = i_w * i_w;
        n_prod.xy = i_x * i_y;
        n_prod.xz = i_x * i_z;
        n_prod.yz = i_y * i_z;
        n_prod.xw = i_x * i_w;
        n_prod.yw = i_y * i_w;
        n_prod.zw = i_z * i_w;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;
endmodule

FILE: sv/qrm_sum.sv
// ----------------------------------------------------------------------------
// qrm_sum
// Registered stage forming the norm and the nine rounded dividends.
// ----------------------------------------------------------------------------
module qrm_sum (
    input  logic             i_clk,
    input  logic             i_en,
    input  qrm_pkg::t_prod   i_prod,
    output qrm_pkg::t_div    o_div
);
    localparam int unsigned NW = qrm_pkg::NUM_W;

    logic [qrm_pkg::N_W-1:0]  n_sq;
    logic signed [NW-1:0]     s_n, s_xx, s_yy, s_zz;
    logic signed [NW-1:0]     s_xy, s_xz, s_yz, s_xw, s_yw, s_zw;
    qrm_pkg::t_lane           lanes [qrm_pkg::N_ENT];
    qrm_pkg::t_div            n_div;
    qrm_pkg::t_div            r_div;

    always_comb begin
        n_sq = qrm_pkg::N_W'($unsigned(i_prod.xx)) + qrm_pkg::N_W'($unsigned(i_prod.yy))
             + qrm_pkg::N_W'($unsigned(i_prod.zz)) + qrm_pkg::N_W'($unsigned(i_prod.ww));
        s_n  = $signed(NW'(n_sq));
        s_xx = NW'(i_prod.xx);
        s_yy = NW'(i_prod.yy);
        s_zz = NW'(i_prod.zz);
        s_xy = NW'(i_prod.xy);
        s_xz = NW'(i_prod.xz);
        s_yz = NW'(i_prod.yz);
        s_xw = NW'(i_prod.xw);
        s_yw = NW'(i_prod.yw);
        s_zw = NW'(i_prod.zw);

        lanes[0] = qrm_pkg::make_lane(s_n - ((s_yy + s_zz) <<< 1), 1'b1, n_sq);
        lanes[1] = qrm_pkg::make_lane(s_xy - s_zw, 1'b0, n_sq);
        lanes[2] = qrm_pkg::make_lane(s_xz + s_yw, 1'b0, n_sq);
        lanes[3] = qrm_pkg::make_lane(s_xy + s_zw, 1'b0, n_sq);
        lanes[4] = qrm_pkg::make_lane(s_n - ((s_xx + s_zz) <<< 1), 1'b1, n_sq);
        lanes[5] = qrm_pkg::make_lane(s_yz - s_xw, 1'b0, n_sq);
        lanes[6] = qrm_pkg::make_lane(s_xz - s_yw, 1'b0, n_sq);
        lanes[7] = qrm_pkg::make_lane(s_yz + s_xw, 1'b0, n_sq);
        lanes[8] = qrm_pkg::make_lane(s_n - ((s_xx + s_yy) <<< 1), 1'b1, n_sq);

        n_div.n    = n_sq;
        n_div.zero = (n_sq == '0);
        for (int l = 0; l < qrm_pkg::N_ENT; l++) begin
            n_div.neg[l] = lanes[l].neg;
            n_div.rem[l] = lanes[l].rem;
            n_div.quo[l] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;
endmodule

FILE: sv/qrm_div_step.sv
// ----------------------------------------------------------------------------
// qrm_div_step
// One registered restoring-division step that settles quotient bit SH of all
// nine entries.
// ----------------------------------------------------------------------------
module qrm_div_step #(
    parameter int unsigned SH = 14
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  qrm_pkg::t_div   i_div,
    output qrm_pkg::t_div   o_div
);
    logic [qrm_pkg::REM_W-1:0] trial;
    qrm_pkg::t_div             n_div;
    qrm_pkg::t_div             r_div;

    assign trial = qrm_pkg::REM_W'(i_div.n) << SH;

    always_comb begin
        n_div = i_div;
        for (int l = 0; l < qrm_pkg::N_ENT; l++) begin
            if (i_div.rem[l] >= trial) begin
                n_div.rem[l]     = i_div.rem[l] - trial;
                n_div.quo[l][SH] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;
endmodule

FILE: sv/quaternion_to_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core
// Converts a Q4.12 quaternion, normalized or not, into a Q2.14 3x3 rotation
// matrix with exact rounded division by the squared norm.
// ----------------------------------------------------------------------------
// Each request is one quaternion (x, y, z, w) in Q4.12 and yields one result:
// the nine row-major matrix entries in Q2.14 and a zero_norm flag. Each entry
// is the exact quotient of a product combination by n = x^2+y^2+z^2+w^2,
// rounded to nearest with ties away from zero. A zero quaternion gives the
// identity matrix with zero_norm set. The block is fully pipelined and takes
// one request per clock while the output is not held off. The pipeline holds
// the product stage, the sum stage, the 15-step restoring divider with one
// quotient bit per stage for all nine entries in parallel, and the output
// register. Every stage moves when it is empty or when the stage after it
// moves, so bubbles are squeezed out and a request can still be taken while
// a finished result waits, as long as some stage is empty.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qrm_in_if.sink        i_in,
    qrm_out_if.source     o_out
);
    // Stage 0 products, stage 1 sums, stages 2..16 divide, stage 17 output.
    localparam int unsigned N_DIV = qrm_pkg::Q_BITS;
    localparam int unsigned N_STG = N_DIV + 3;

    logic [N_STG-1:0] r_vld;
    logic [N_STG:0]   en;

    qrm_pkg::t_prod   prod;
    qrm_pkg::t_div    div [N_DIV+1];

    // Advance chain: a stage loads when it is empty or its successor loads.
    always_comb begin
        en[N_STG] = o_out.ready;
        for (int k = N_STG - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_in.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < N_STG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    qrm_prod u_prod (
        .i_clk  (i_clk),
        .i_en   (en[0]),
        .i_x    (i_in.q_x),
        .i_y    (i_in.q_y),
        .i_z    (i_in.q_z),
        .i_w    (i_in.q_w),
        .o_prod (prod)
    );

    qrm_sum u_sum (
        .i_clk  (i_clk),
        .i_en   (en[1]),
        .i_prod (prod),
        .o_div  (div[0])
    );

    // Quotient bits are settled most significant first.
    for (genvar g = 0; g < N_DIV; g++) begin : g_div
        qrm_div_step #(
            .SH (N_DIV - 1 - g)
        ) u_step (
            .i_clk (i_clk),
            .i_en  (en[g+2]),
            .i_div (div[g]),
            .o_div (div[g+1])
        );
    end

    // Output stage: apply the sign, then substitute the identity matrix when
    // the norm was zero. The quotient magnitude never exceeds 2^14, so the
    // signed 16-bit result is already within the saturation bounds.
    logic signed [15:0] n_m [qrm_pkg::N_ENT];
    logic signed [15:0] r_m [qrm_pkg::N_ENT];
    logic               r_zero;

    always_comb begin
        for (int l = 0; l < qrm_pkg::N_ENT; l++) begin
            if (div[N_DIV].zero) begin
                n_m[l] = (l == 0 || l == 4 || l == 8) ? qrm_pkg::QONE : 16'sd0;
            end else if (div[N_DIV].neg[l]) begin
                n_m[l] = -$signed({1'b0, div[N_DIV].quo[l]});
            end else begin
                n_m[l] = $signed({1'b0, div[N_DIV].quo[l]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[N_STG-1]) begin
            r_m    <= n_m;
            r_zero <= div[N_DIV].zero;
        end
    end

    assign o_out.valid     = r_vld[N_STG-1];
    assign o_out.m00       = r_m[0];
    assign o_out.m01       = r_m[1];
    assign o_out.m02       = r_m[2];
    assign o_out.m10       = r_m[3];
    assign o_out.m11       = r_m[4];
    assign o_out.m12       = r_m[5];
    assign o_out.m20       = r_m[6];
    assign o_out.m21       = r_m[7];
    assign o_out.m22       = r_m[8];
    assign o_out.zero_norm = r_zero;
endmodule

FILE: bench/quaternion_to_rotation_matrix_core_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core_tb
// Self-checking bench for the quaternion to rotation matrix core. Quaternion
// requests are driven over the input channel and every matrix result is
// compared entry by entry with a bit-exact predictor of the rounded division.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The final drain wait is longer than the core's pipeline.
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } t_quat;

    typedef struct packed {
        logic signed [8:0][15:0] m;
        logic                    zero_norm;
    } t_matrix;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    qrm_in_if  in_ch();
    qrm_out_if out_ch();

    quaternion_to_rotation_matrix_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // Expected matrices in request order, and run bookkeeping.
    t_matrix expected_matrices[$];
    int      mismatch_count = 0;
    int      request_count  = 0;
    int      result_count   = 0;
    int      zero_count     = 0;

    // Idle rates in percent, and a long receiver hold-off when nonzero.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          recv_hold_cycles = 0;

    // Rounded quotient num * 2^shift / n, nearest, ties away from zero,
    // saturated to the 16-bit signed range.
    function automatic logic signed [15:0] rounded_ratio(input longint num,
                                                         input int shift,
                                                         input longint n);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = ((mag << shift) + (n >>> 1)) / n;
        if (q > 32768) q = 32768;
        if (num < 0) q = -q;
        if (q > 32767) q = 32767;
        return 16'(q);
    endfunction

    // Predict the rotation matrix for one quaternion.
    function automatic t_matrix rotation_of(input t_quat q);
        t_matrix r;
        longint  x, y, z, w, xx, yy, zz, ww, n;
        x = q.x; y = q.y; z = q.z; w = q.w;
        xx = x * x; yy = y * y; zz = z * z; ww = w * w;
        n  = xx + yy + zz + ww;
        r  = '0;
        if (n == 0) begin
            // The zero quaternion falls back to the identity with the flag.
            r.m[8] = qrm_pkg::QONE;
            r.m[4] = qrm_pkg::QONE;
            r.m[0] = qrm_pkg::QONE;
            r.zero_norm = 1'b1;
        end else begin
            // Entry k of the row-major matrix sits at m[8-k].
            r.m[8] = rounded_ratio(n - 2 * (yy + zz), 14, n);
            r.m[7] = rounded_ratio(x * y - z * w, 15, n);
            r.m[6] = rounded_ratio(x * z + y * w, 15, n);
            r.m[5] = rounded_ratio(x * y + z * w, 15, n);
            r.m[4] = rounded_ratio(n - 2 * (xx + zz), 14, n);
            r.m[3] = rounded_ratio(y * z - x * w, 15, n);
            r.m[2] = rounded_ratio(x * z - y * w, 15, n);
            r.m[1] = rounded_ratio(y * z + x * w, 15, n);
            r.m[0] = rounded_ratio(n - 2 * (xx + yy), 14, n);
        end
        return r;
    endfunction

    // Offer one request, with a random idle gap first, and wait for it to be
    // taken. Valid stays high between back-to-back requests.
    task automatic send_quat(input t_quat q);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.q_x   <= q.x;
        in_ch.q_y   <= q.y;
        in_ch.q_z   <= q.z;
        in_ch.q_w   <= q.w;
        expected_matrices.push_back(rotation_of(q));
        request_count++;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic release_valid();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every expected result has come back.
    task automatic wait_drained();
        release_valid();
        while (expected_matrices.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_quat random_quat();
        t_quat q;
        int    mode;
        mode = $urandom_range(9);
        q = {$urandom, $urandom};
        // Small magnitudes exercise rounding close to ties and sparse values.
        if (mode < 3) begin
            q.x = 16'(int'($urandom_range(6)) - 3);
            q.y = 16'(int'($urandom_range(6)) - 3);
            q.z = 16'(int'($urandom_range(6)) - 3);
            q.w = 16'(int'($urandom_range(6)) - 3);
        end else if (mode == 3) begin
            // Components within +/-1.0 in Q4.12 cover the range of usual pose data.
            q.x = 16'(int'($urandom_range(8192)) - 4096);
            q.y = 16'(int'($urandom_range(8192)) - 4096);
            q.z = 16'(int'($urandom_range(8192)) - 4096);
            q.w = 16'(int'($urandom_range(8192)) - 4096);
        end else if (mode == 4) begin
            if ($urandom_range(1)) q.x = 0;
            if ($urandom_range(1)) q.y = 0;
            if ($urandom_range(1)) q.z = 0;
            if ($urandom_range(1)) q.w = 0;
        end
        return q;
    endfunction

    // Receiver: random stalls, an optional long hold-off, field checks.
    always @(posedge i_clk) begin
        t_matrix got;
        t_matrix want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.m = {out_ch.m00, out_ch.m01, out_ch.m02, out_ch.m10, out_ch.m11,
                         out_ch.m12, out_ch.m20, out_ch.m21, out_ch.m22};
                got.zero_norm = out_ch.zero_norm;
                result_count++;
                if (expected_matrices.size() == 0) begin
                    $error("Matrix result with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_matrices.pop_front();
                    if (want.zero_norm) zero_count++;
                    for (int k = 0; k < 9; k++) begin
                        if (got.m[8-k] !== want.m[8-k]) begin
                            $error("m%0d%0d: expected %0d, actual %0d", k / 3, k % 3,
                                   $signed(want.m[8-k]), $signed(got.m[8-k]));
                            mismatch_count++;
                        end
                    end
                    if (got.zero_norm !== want.zero_norm) begin
                        $error("zero_norm: expected %0d, actual %0d",
                               want.zero_norm, got.zero_norm);
                        mismatch_count++;
                    end
                end
            end
            if (recv_hold_cycles > 0) begin
                recv_hold_cycles <= recv_hold_cycles - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Extremes of every field, single components, sign combinations, and the
    // zero quaternion.
    task automatic test_directed();
        t_quat list[$];
        list.push_back('{0, 0, 0, 0});
        list.push_back('{0, 0, 0, 4096});
        list.push_back('{4096, 0, 0, 0});
        list.push_back('{0, 4096, 0, 0});
        list.push_back('{0, 0, 4096, 0});
        list.push_back('{-32768, -32768, -32768, -32768});
        list.push_back('{32767, 32767, 32767, 32767});
        list.push_back('{-32768, 32767, -32768, 32767});
        list.push_back('{32767, -32768, 0, 0});
        list.push_back('{1, 0, 0, 0});
        list.push_back('{0, 0, 0, -1});
        list.push_back('{1, 1, 1, 1});
        list.push_back('{-1, 1, -1, 1});
        list.push_back('{2896, 0, 0, 2896});
        list.push_back('{1, 2, 3, 4});
        list.push_back('{-21846, 21845, 10922, -10923});
        list.push_back('{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA});
        list.push_back('{0, 0, 0, 0});
        list.push_back('{0, 0, 1, 0});
        foreach (list[i]) send_quat(list[i]);
        wait_drained();
    endtask

    task automatic test_random(input int count, input int unsigned send_pct,
                               input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_quat(random_quat());
        wait_drained();
    endtask

    // Hold the result side off long enough for the pipeline to fill and
    // push back on the request side.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_cycles = 60;
        repeat (40) send_quat(random_quat());
        wait_drained();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.q_x   = '0;
        in_ch.q_y   = '0;
        in_ch.q_z   = '0;
        in_ch.q_w   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(400, 16, 85);
        test_random(400, 85, 16);
        test_backpressure();
        test_random(400, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d quaternions and checked %0d matrices (%0d zero-norm),",
                 request_count, result_count, zero_count);
        $display("under both idle mixes, a long output stall and full rate.");
        if (mismatch_count == 0 && expected_matrices.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (expected_matrices.size() != 0)
                $error("%0d matrices never arrived", expected_matrices.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
